>>> rtl/core/pnrf_pkg.sv
// Shared constants for the polynomial Newton root finder.
package pnrf_pkg;
    localparam logic [1:0] ST_CONVERGED = 2'd0;
    localparam logic [1:0] ST_NO_ROOT   = 2'd1;
    localparam logic [1:0] ST_OVERFLOW  = 2'd2;
    localparam logic [1:0] REG_TOL   = 2'd0;
    localparam logic [1:0] REG_LIMIT = 2'd1;
    localparam logic [1:0] REG_SLOPE = 2'd2;
endpackage

>>> rtl/core/polynomial_newton_root_finder.sv
// Newton root finder for a Q16.16 polynomial: coefficients load one per cycle, lowest
// order first, into a coefficient memory; the transfer marked tlast starts the solve.
// Each iteration runs one check state, then per term a memory read, a registered
// multiply and an accumulate for the Horner steps of p and p', then a restoring
// divider that retires one of 48 quotient bits a cycle (bypassed when p' is zero).
// The final check and the load of the result register follow the last iteration.
// Input is held off from the last transfer until the result has moved into the
// output register; an overflow result skips the solve and goes straight to output.
module polynomial_newton_root_finder #(
    parameter int MAX_TERMS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // coef_value
    input  logic        s_axis_tlast,   // coef_last
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // root[31:0], status[33:32], iterations[49:34], zeros
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import pnrf_pkg::*;
    localparam int AW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
    localparam int CW = $clog2(MAX_TERMS + 1);
    localparam logic signed [63:0] VMAX = 64'sd2147483647;
    localparam logic signed [63:0] VMIN = -64'sd2147483648;

    typedef enum logic [2:0] {S_LOAD, S_CHECK, S_RD, S_MUL, S_ACC, S_DIV, S_OUT} t_state;

    t_state r_state;
    logic [30:0] r_tol, r_slope;
    logic [15:0] r_limit;
    logic signed [31:0] r_mem [MAX_TERMS];
    logic signed [31:0] r_rd;
    logic [CW-1:0] r_cnt, r_k;
    logic r_ovf;
    logic signed [31:0] r_x, r_x1, r_dfx, r_fx, r_df;
    logic signed [63:0] r_pf, r_pd;
    logic [15:0] r_iter;
    logic [1:0] r_st;
    logic r_out_v;
    logic [31:0] r_out_root;
    logic [1:0] r_out_st;
    logic [15:0] r_out_it;
    // divider
    logic [47:0] r_num, r_quo;
    logic [63:0] r_rem;
    logic [31:0] r_den;
    logic [5:0] r_bit;
    logic r_neg;

    function automatic logic signed [31:0] sat64(input logic signed [63:0] v);
        if (v > VMAX) return 32'sh7fffffff;
        if (v < VMIN) return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic logic [32:0] mag32(input logic signed [31:0] v);
        return v[31] ? 33'(-{v[31], v}) : {1'b0, v};
    endfunction

    wire cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    always_comb begin
        case (paddr[3:2])
            REG_TOL:   prdata = {1'b0, r_tol};
            REG_LIMIT: prdata = {16'd0, r_limit};
            REG_SLOPE: prdata = {1'b0, r_slope};
            default:   prdata = 32'd0;
        endcase
    end

    assign s_axis_tready = (r_state == S_LOAD);
    wire in_xfer = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata = {6'd0, r_out_it, r_out_st, r_out_root};

    // Horner index runs from cnt-1 down to 0; memory read precedes each step.
    wire [AW-1:0] rd_addr = r_k[AW-1:0];
    always_ff @(posedge i_clk) begin
        if (in_xfer && r_cnt < CW'(MAX_TERMS)) r_mem[r_cnt[AW-1:0]] <= s_axis_tdata;
        r_rd <= r_mem[rd_addr];
    end

    wire [32:0] step_mag = mag32(sat64(64'(r_x1) - 64'(r_x)));
    wire [32:0] df_mag = mag32(r_dfx);
    wire signed [63:0] kc = $signed({1'b0, 32'(r_k)}) * 64'(r_rd);
    wire signed [63:0] fr = (r_pf + 64'sd32768) >>> 16;
    wire signed [63:0] dr = (r_pd + 64'sd32768) >>> 16;
    wire signed [31:0] fx_next = sat64(64'(sat64(fr)) + 64'(r_rd));
    wire [32:0] fx_next_mag = mag32(fx_next);
    wire [32:0] df_acc_mag = mag32(r_df);
    wire [63:0] trial = {r_rem[62:0], r_num[r_bit]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD; r_cnt <= '0; r_ovf <= 1'b0; r_out_v <= 1'b0;
            r_tol <= 31'd66; r_limit <= 16'd1000; r_slope <= 31'd0;
        end else begin
            if (cfg_wr) begin
                case (paddr[3:2])
                    REG_TOL:   r_tol <= pwdata[30:0];
                    REG_LIMIT: r_limit <= pwdata[15:0];
                    REG_SLOPE: r_slope <= pwdata[30:0];
                    default: ;
                endcase
            end
            if (r_out_v && m_axis_tready) r_out_v <= 1'b0;
            case (r_state)
                S_LOAD: if (in_xfer) begin
                    if (r_cnt < CW'(MAX_TERMS)) r_cnt <= r_cnt + 1'b1;
                    else r_ovf <= 1'b1;
                    if (s_axis_tlast) begin
                        if (r_ovf || r_cnt >= CW'(MAX_TERMS)) begin
                            r_x <= '0; r_iter <= '0; r_st <= ST_OVERFLOW;
                            r_state <= S_OUT;
                        end else begin
                            r_x <= '0; r_x1 <= 32'sh10000; r_dfx <= 32'sh10000;
                            r_iter <= '0; r_state <= S_CHECK;
                        end
                    end
                end
                S_CHECK: begin
                    if (step_mag < {2'b0, r_tol}) begin
                        r_st <= ST_CONVERGED; r_state <= S_OUT;
                    end else if (r_iter >= r_limit) begin
                        r_st <= ST_NO_ROOT; r_state <= S_OUT;
                    end else begin
                        r_iter <= r_iter + 1'b1;
                        r_x <= r_x1;
                        if (17'(r_iter) + 17'd2 == {1'b0, r_limit} ||
                            df_mag <= {2'b0, r_slope}) begin
                            r_st <= ST_NO_ROOT; r_state <= S_OUT;
                        end else begin
                            r_fx <= '0; r_df <= '0;
                            r_k <= r_cnt - 1'b1;
                            r_state <= S_RD;
                        end
                    end
                end
                S_RD: r_state <= S_MUL;
                S_MUL: begin
                    r_pf <= r_fx * r_x;
                    r_pd <= r_df * r_x;
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    r_fx <= fx_next;
                    if (r_k != '0) r_df <= sat64(64'(sat64(dr)) + 64'(sat64(kc)));
                    if (r_k == '0) begin
                        r_dfx <= r_df;
                        r_num <= 48'(fx_next_mag) << 16;
                        r_den <= df_acc_mag[31:0];
                        r_neg <= fx_next[31] ^ r_df[31];
                        r_rem <= '0; r_quo <= '0; r_bit <= 6'd47;
                        r_state <= S_DIV;
                    end else begin
                        r_k <= r_k - 1'b1;
                        r_state <= S_RD;
                    end
                end
                S_DIV: begin
                    if (r_dfx == '0) begin
                        r_x1 <= (r_fx == '0) ? r_x :
                            sat64(64'(r_x) - (r_fx[31] ? VMIN : VMAX));
                        r_state <= S_CHECK;
                    end else begin
                        if (trial >= {32'd0, r_den}) begin
                            r_rem <= trial - {32'd0, r_den}; r_quo[r_bit] <= 1'b1;
                        end else r_rem <= trial;
                        if (r_bit == 6'd0) begin
                            r_state <= S_CHECK;
                        end else r_bit <= r_bit - 1'b1;
                    end
                end
                S_OUT: if (!r_out_v) begin
                    r_out_root <= r_x; r_out_st <= r_st; r_out_it <= r_iter;
                    r_out_v <= 1'b1;
                    r_cnt <= '0; r_ovf <= 1'b0; r_state <= S_LOAD;
                end
                default: r_state <= S_LOAD;
            endcase
            // Divider finished: subtract the signed quotient from x to form x1 on the transition back.
            if (r_state == S_DIV && r_dfx != '0 && r_bit == 6'd0) begin
                r_x1 <= sat64(64'(r_x) - 64'(sat64(r_neg ?
                    -$signed({16'd0, r_quo[47:1], trial >= {32'd0, r_den}}) :
                    $signed({16'd0, r_quo[47:1], trial >= {32'd0, r_den}}))));
            end
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> r_state == S_LOAD) else $error("tready outside load");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(MAX_TERMS)) else $error("term count overrun");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid) else $error("result dropped");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v |-> r_out_st <= ST_OVERFLOW) else $error("bad status");
endmodule

>>> tb/tb_polynomial_newton_root_finder.sv
// Self-checking testbench for the polynomial Newton root finder: stream stimulus and checks.
module tb_polynomial_newton_root_finder;
    import pnrf_pkg::*;

    localparam int  TERMS     = 16;
    localparam longint VMAX   = 64'sd2147483647;
    localparam longint VMIN   = -64'sd2147483648;
    localparam longint Q1     = 64'sd65536;
    localparam int  CYCLE_CAP = 4000000;

    typedef struct packed {
        logic [31:0] coef;
        logic        last;
    } t_coef_item;

    typedef struct packed {
        logic [31:0] root;
        logic [1:0]  status;
        logic [15:0] iters;
    } t_solution;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;   // coef_value
    logic        s_axis_tlast = 1'b0; // coef_last
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [55:0] m_axis_tdata;        // root[31:0], status[33:32], iterations[49:34], zeros
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    polynomial_newton_root_finder i_dut (.*);

    always #2 i_clk = ~i_clk;

    // Predictor state and register copies.
    longint      tol_q = 66;
    longint      limit_q = 1000;
    longint      slope_q = 0;
    longint      coef_mem [TERMS];
    int          loaded = 0;
    bit          dropped = 0;

    t_coef_item  pending_coefs [$];
    t_solution   expected_solutions [$];
    int          failures = 0;
    int          cycles = 0;
    bit          calm_sender = 0;
    bit          calm_receiver = 0;
    int          send_gap = 0;

    function automatic longint sat32(longint v);
        if (v > VMAX) return VMAX;
        if (v < VMIN) return VMIN;
        return v;
    endfunction

    function automatic longint qmul(longint a, longint b);
        return sat32((a * b + 32768) >>> 16);
    endfunction

    function automatic longint horner_eval(longint c [TERMS], int n, longint x);
        longint acc;
        if (n == 0) return 0;
        acc = c[n-1];
        for (int k = n - 1; k > 0; k--) acc = sat32(qmul(acc, x) + c[k-1]);
        return acc;
    endfunction

    function automatic longint qdiv(longint num, longint den);
        if (den == 0) begin
            if (num == 0) return 0;
            return num > 0 ? VMAX : VMIN;
        end
        return sat32((num * 65536) / den);
    endfunction

    function automatic longint magnitude(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic t_solution newton_solve(int n);
        longint    slope_coefs [TERMS];
        longint    x, x1, dfx, fx, iter;
        logic [1:0] st;
        t_solution r;
        x = 0;
        x1 = Q1;
        dfx = Q1;
        iter = 0;
        st = ST_CONVERGED;
        for (int i = 0; i < TERMS; i++) slope_coefs[i] = 0;
        for (int i = 0; i + 1 < n; i++) slope_coefs[i] = sat32(longint'(i + 1) * coef_mem[i+1]);
        forever begin
            if (magnitude(x1 - x) < tol_q) begin
                st = ST_CONVERGED;
                break;
            end
            if (iter >= limit_q) begin
                st = ST_NO_ROOT;
                break;
            end
            iter++;
            x = x1;
            if (iter + 1 == limit_q || magnitude(dfx) <= slope_q) begin
                st = ST_NO_ROOT;
                break;
            end
            fx = horner_eval(coef_mem, n, x);
            dfx = horner_eval(slope_coefs, n - 1, x);
            x1 = sat32(x - qdiv(fx, dfx));
        end
        r.root = x[31:0];
        r.status = st;
        r.iters = iter[15:0];
        return r;
    endfunction

    function automatic void absorb_coef(t_coef_item it);
        t_solution r;
        if (loaded < TERMS) begin
            coef_mem[loaded] = longint'(signed'(it.coef));
            loaded++;
        end else begin
            dropped = 1;
        end
        if (it.last) begin
            if (dropped) begin
                r.root = '0;
                r.status = ST_OVERFLOW;
                r.iters = '0;
            end else begin
                r = newton_solve(loaded);
            end
            expected_solutions.push_back(r);
            loaded = 0;
            dropped = 0;
        end
    endfunction

    function automatic int pick_gap(bit calm);
        if (calm || $urandom_range(0, 9) < 6) return 0;
        if ($urandom_range(0, 15) == 0) return $urandom_range(8, 40);
        return $urandom_range(1, 3);
    endfunction

    // Driver: pops the next coefficient once the current transfer is done.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                s_axis_tvalid <= 1'b0;
            end else if (pending_coefs.size() > 0) begin
                s_axis_tdata <= pending_coefs[0].coef;
                s_axis_tlast <= pending_coefs[0].last;
                s_axis_tvalid <= 1'b1;
                void'(pending_coefs.pop_front());
                send_gap <= pick_gap(calm_sender);
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: predicts on each input transfer and checks each output transfer.
    always @(posedge i_clk) begin
        t_solution got;
        t_solution want;
        cycles <= cycles + 1;
        if (i_rst_n) begin
            m_axis_tready <= calm_receiver ? 1'b1 :
                ($urandom_range(0, 31) == 0 ? 1'b0 : ($urandom_range(0, 3) != 0));
            if (s_axis_tvalid && s_axis_tready)
                absorb_coef('{coef: s_axis_tdata, last: s_axis_tlast});
            if (m_axis_tvalid && m_axis_tready) begin
                got.root = m_axis_tdata[31:0];
                got.status = m_axis_tdata[33:32];
                got.iters = m_axis_tdata[49:34];
                if (expected_solutions.size() == 0) begin
                    $display("%0t: unexpected result root=%h status=%0d iterations=%0d",
                             $time, got.root, got.status, got.iters);
                    failures++;
                end else begin
                    want = expected_solutions.pop_front();
                    if (got.root !== want.root)
                        $display("%0t: root expected %h actual %h", $time, want.root, got.root);
                    if (got.status !== want.status)
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, got.status);
                    if (got.iters !== want.iters)
                        $display("%0t: iterations expected %0d actual %0d",
                                 $time, want.iters, got.iters);
                    if (got !== want) failures++;
                end
            end
        end
        if (cycles > CYCLE_CAP) begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic reg_write(logic [1:0] idx, longint value);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value[31:0];
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_TOL:   tol_q = value & 64'h7FFF_FFFF;
            REG_LIMIT: limit_q = value & 64'hFFFF;
            REG_SLOPE: slope_q = value & 64'h7FFF_FFFF;
            default: ;
        endcase
    endtask

    // Hold off until every queued coefficient has gone in and every result has come out.
    task automatic drain();
        while (pending_coefs.size() > 0 || s_axis_tvalid || expected_solutions.size() > 0)
            @(posedge i_clk);
        repeat (50) @(posedge i_clk);
    endtask

    task automatic set_regs(longint tol, longint lim, longint slope);
        drain();
        reg_write(REG_TOL, tol);
        reg_write(REG_LIMIT, lim);
        reg_write(REG_SLOPE, slope);
    endtask

    task automatic push_coef(logic [31:0] c, bit last);
        pending_coefs.push_back('{coef: c, last: last});
    endtask

    function automatic logic [31:0] random_coef();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5) return 32'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
        if (r < 6) return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
        if (r < 7) return {$urandom_range(0, 1) ? 16'h0 : 16'hFFFF, 16'($urandom)};
        return $urandom;
    endfunction

    task automatic random_frames(int count);
        int len;
        while (count > 0) begin
            len = ($urandom_range(0, 19) == 0) ? $urandom_range(TERMS + 1, TERMS + 3)
                                               : $urandom_range(1, 5);
            if ($urandom_range(0, 29) == 0) len = TERMS;
            for (int i = 0; i < len; i++) push_coef(random_coef(), i == len - 1);
            count -= len;
            while (pending_coefs.size() > 8) @(posedge i_clk);
        end
    endtask

    initial begin
        longint tols [6];
        longint lims [6];
        longint slopes [6];
        for (int i = 0; i < TERMS; i++) coef_mem[i] = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: x - 2, a constant, then extreme coefficients.
        push_coef(32'hFFFE_0000, 0);
        push_coef(32'h0001_0000, 1);
        push_coef(32'h0005_0000, 1);
        push_coef(32'h8000_0000, 0);
        push_coef(32'h7FFF_FFFF, 1);
        // Zero polynomial: zero slope with zero value gives a zero step.
        push_coef(32'h0, 0);
        push_coef(32'h0, 1);
        set_regs(66, 20, 0);
        // x^2 + 1 has no real root and ends with no root on a zero slope; x^2 - 2 converges.
        push_coef(32'h0001_0000, 0);
        push_coef(32'h0, 0);
        push_coef(32'h0001_0000, 1);
        push_coef(32'hFFFE_0000, 0);
        push_coef(32'h0, 0);
        push_coef(32'h0001_0000, 1);
        // More coefficients than the store holds.
        for (int i = 0; i < TERMS + 2; i++) push_coef($urandom, i == TERMS + 1);

        tols   = '{1, 66, 2000, 40000, 70000, 7};
        lims   = '{2, 12, 24, 8, 3, 16};
        slopes = '{0, 2147483647, 1 << 14, 0, 100, 1 << 18};
        for (int p = 0; p < 6; p++) begin
            set_regs(tols[p], lims[p], slopes[p]);
            calm_sender = (p == 2);
            calm_receiver = (p == 3);
            random_frames(100);
        end
        // Widest limit with the widest tolerance: every solve ends at once.
        set_regs(2147483647, 65535, 0);
        random_frames(60);
        set_regs(66, 1000, 0);
        push_coef(32'hFFFD_0000, 0);
        push_coef(32'h0001_0000, 1);
        calm_sender = 0;
        calm_receiver = 0;
        set_regs(300, 10, 50);
        random_frames(40);
        drain();
        if (failures == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
